@@ design/tesp_pkg.sv @@
// Shared types and constants for the terminal escape sequence parser.
`default_nettype none
package tesp_pkg;
	localparam int MaxParams = 16;
	localparam int OscDepth = 64;
	localparam int ArgIdxW = $clog2(MaxParams);
	localparam int ArgCntW = $clog2(MaxParams + 1);
	localparam int OscIdxW = (OscDepth > 1) ? $clog2(OscDepth) : 1;
	localparam int OscCntW = $clog2(OscDepth + 1);
	localparam int CodeW = 21;
	localparam int ValW = 17;

	localparam logic [2:0] EV_CONTROL = 3'd0;
	localparam logic [2:0] EV_ESCAPE = 3'd1;
	localparam logic [2:0] EV_CSI = 3'd2;
	localparam logic [2:0] EV_PRINT = 3'd3;
	localparam logic [2:0] EV_OSC = 3'd4;

	typedef enum logic [7:0] {
		ST_GROUND = 8'b0000_0001,
		ST_ESC = 8'b0000_0010,
		ST_ESC_INT = 8'b0000_0100,
		ST_CSI_ENTRY = 8'b0000_1000,
		ST_CSI_IGNORE = 8'b0001_0000,
		ST_CSI_PARAM = 8'b0010_0000,
		ST_CSI_INT = 8'b0100_0000,
		ST_OSC = 8'b1000_0000
	} pstate_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic clear;
		logic keep_int;
		logic take_param;
		logic osc_push;
		logic load_ev;
		logic [2:0] ev_kind;
		logic [CodeW-1:0] ev_code;
		logic start_burst;
	} tesp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic busy;
	} tesp_sts_t;
endpackage
`default_nettype wire

@@ design/terminal_escape_sequence_parser.sv @@
// Top level of the terminal escape sequence parser.
// A print, control or escape event is registered and appears in the cycle after its character transfer.
// A CSI or OSC dispatch emits its results one after another, each after a read wait (pend_q).
// Input takes one character per cycle while no burst runs and no result waits; a dispatch
// blocks input until its last result is out, as the argument and OSC stores give one entry at a time.
// Reset (arst_n low) returns to ground and clears the collected data; OSC store is not cleared.
`default_nettype none
module terminal_escape_sequence_parser import tesp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [23:0] s_tdata, // [20:0] char_code, upper bits zero
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [63:0] m_tdata, // [2:0] event_kind, [23:3] code, [30:24] intermediate,
	                             // [37:31] item_count, [43:38] item_index, [60:44] item_value
	output logic m_tlast
);
	tesp_cmd_t cmd;
	tesp_sts_t sts;
	logic osc_full, in_fire;
	logic [2:0] k;
	logic [CodeW-1:0] cd;
	logic [6:0] it, ct;
	logic [5:0] ix;
	logic [ValW-1:0] vl;

	// Accept a character only when no burst runs and the output slot is free or draining.
	assign s_tready = !sts.busy && (!m_tvalid || m_tready);
	assign in_fire = s_tvalid && s_tready;

	tesp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .c(s_tdata[CodeW-1:0]),
		.osc_full(osc_full), .cmd(cmd)
	);

	tesp_dp u_dp (
		.clk(clk), .arst_n(arst_n), .c(s_tdata[CodeW-1:0]), .cmd(cmd),
		.out_ready(m_tready), .sts(sts), .osc_full(osc_full), .out_valid(m_tvalid),
		.o_kind(k), .o_code(cd), .o_inter(it), .o_count(ct), .o_index(ix),
		.o_value(vl), .o_last(m_tlast)
	);

	assign m_tdata = {3'b000, vl, ix, ct, it, cd, k};
endmodule
`default_nettype wire

@@ design/tesp_ctrl.sv @@
// Parser state machine: classifies each character and issues datapath commands.
`default_nettype none
module tesp_ctrl import tesp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic [CodeW-1:0] c,
	input wire logic osc_full,
	output tesp_cmd_t cmd
);
	pstate_t state_q, nxt;
	logic go, clr;

	always_comb begin
		logic is_int, is_dig, is_fin;
		cmd = '0;
		cmd.ev_code = c;
		nxt = state_q;
		go = 1'b0;
		is_int = (c >= 21'h20) && (c <= 21'h2f);
		is_dig = ((c >= 21'h30) && (c <= 21'h39)) || (c == 21'h3b);
		is_fin = (c >= 21'h40) && (c <= 21'h7e);
		if (c == 21'h00 || c == 21'h7f) begin
		end else if (c == 21'h18 || c == 21'h1a) begin
			cmd.load_ev = 1'b1; cmd.ev_kind = EV_CONTROL; nxt = ST_GROUND; go = 1'b1;
		end else if (c == 21'h1b) begin
			nxt = ST_ESC; go = 1'b1;
		end else if (c < 21'h20 && !(c == 21'h07 && state_q == ST_OSC)) begin
			cmd.load_ev = 1'b1; cmd.ev_kind = EV_CONTROL;
		end else begin
			case (state_q)
				ST_GROUND: begin
					if (c >= 21'h20) begin
						cmd.load_ev = 1'b1; cmd.ev_kind = EV_PRINT;
					end
				end
				ST_ESC: begin
					if (c == 21'h21) begin
						nxt = ST_OSC; go = 1'b1;
					end else if (is_int) begin
						cmd.keep_int = 1'b1; nxt = ST_ESC_INT; go = 1'b1;
					end else if (c == 21'h50 || c == 21'h5d || c == 21'h5e || c == 21'h5f
						|| c == 21'h6b) begin
						nxt = ST_OSC; go = 1'b1;
					end else if (c == 21'h5b) begin
						nxt = ST_CSI_ENTRY; go = 1'b1;
					end else if (c >= 21'h30 && c <= 21'h7e && c != 21'h58) begin
						cmd.load_ev = 1'b1; cmd.ev_kind = EV_ESCAPE; nxt = ST_GROUND; go = 1'b1;
					end
				end
				ST_ESC_INT: begin
					if (is_int) begin
						cmd.keep_int = 1'b1;
					end else if (c >= 21'h30 && c <= 21'h7e) begin
						cmd.load_ev = 1'b1; cmd.ev_kind = EV_ESCAPE; nxt = ST_GROUND; go = 1'b1;
					end
				end
				ST_CSI_ENTRY: begin
					if (is_int) begin
						cmd.keep_int = 1'b1; nxt = ST_CSI_INT; go = 1'b1;
					end else if (c == 21'h3a) begin
						nxt = ST_CSI_IGNORE; go = 1'b1;
					end else if (is_dig) begin
						cmd.take_param = 1'b1; nxt = ST_CSI_PARAM; go = 1'b1;
					end else if (c >= 21'h3c && c <= 21'h3f) begin
						cmd.keep_int = 1'b1; nxt = ST_CSI_PARAM; go = 1'b1;
					end else if (is_fin) begin
						cmd.start_burst = 1'b1; cmd.ev_kind = EV_CSI; nxt = ST_GROUND; go = 1'b1;
					end
				end
				ST_CSI_IGNORE: begin
					if (is_fin) begin
						nxt = ST_GROUND; go = 1'b1;
					end
				end
				ST_CSI_PARAM: begin
					if (is_dig) begin
						cmd.take_param = 1'b1;
					end else if (c == 21'h3a || (c >= 21'h3c && c <= 21'h3f)) begin
						nxt = ST_CSI_IGNORE; go = 1'b1;
					end else if (is_int) begin
						cmd.keep_int = 1'b1; nxt = ST_CSI_INT; go = 1'b1;
					end else if (is_fin) begin
						cmd.start_burst = 1'b1; cmd.ev_kind = EV_CSI; nxt = ST_GROUND; go = 1'b1;
					end
				end
				ST_CSI_INT: begin
					if (is_int) begin
						cmd.keep_int = 1'b1;
					end else if (c >= 21'h30 && c <= 21'h3f) begin
						nxt = ST_CSI_IGNORE; go = 1'b1;
					end else if (is_fin) begin
						cmd.start_burst = 1'b1; cmd.ev_kind = EV_CSI; nxt = ST_GROUND; go = 1'b1;
					end
				end
				ST_OSC: begin
					if (c == 21'h07) begin
						cmd.start_burst = 1'b1; cmd.ev_kind = EV_OSC; nxt = ST_GROUND; go = 1'b1;
					end else if (c >= 21'h20 && c <= 21'h7e && !osc_full) begin
						cmd.osc_push = 1'b1;
					end
				end
				default: nxt = ST_GROUND;
			endcase
		end
		clr = go && (nxt == ST_ESC || nxt == ST_CSI_ENTRY || nxt == ST_OSC);
		cmd.clear = clr;
		if (!in_fire) cmd = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_GROUND;
		end else if (in_fire) begin
			state_q <= nxt;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("parser state not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_burst |=> state_q == ST_GROUND)
		else $error("dispatch did not return to ground");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.start_burst && cmd.load_ev))
		else $error("two events from one character");
endmodule
`default_nettype wire

@@ design/tesp_dp.sv @@
// Datapath: collected data, argument and OSC stores, and the output register.
`default_nettype none
module tesp_dp import tesp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [CodeW-1:0] c,
	input wire tesp_cmd_t cmd,
	input wire logic out_ready,
	output tesp_sts_t sts,
	output logic osc_full,
	output logic out_valid,
	output logic [2:0] o_kind,
	output logic [CodeW-1:0] o_code,
	output logic [6:0] o_inter,
	output logic [6:0] o_count,
	output logic [5:0] o_index,
	output logic [ValW-1:0] o_value,
	output logic o_last
);
	logic [6:0] inter_q;
	logic [ArgCntW-1:0] argc_q;
	logic [ValW-1:0] args_q [MaxParams];
	logic [OscCntW-1:0] oscc_q;
	logic [6:0] osc_mem [OscDepth];
	logic [6:0] osc_rd_q;
	logic burst_q, is_osc_q, oval_q, pend_q;
	logic [6:0] idx_q, tot_q;
	logic [ValW-1:0] arg_rd;
	logic out_free;
	logic emit;
	logic [ArgIdxW-1:0] cur;

	assign osc_full = (oscc_q == OscCntW'(OscDepth));
	assign out_free = !oval_q || out_ready;
	assign emit = burst_q && !pend_q && out_free;
	assign sts.busy = burst_q || pend_q;
	assign out_valid = oval_q;
	assign cur = (argc_q == '0) ? '0 : ArgIdxW'(argc_q - 1'b1);
	assign arg_rd = args_q[idx_q[ArgIdxW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inter_q <= '0;
			argc_q <= '0;
			oscc_q <= '0;
			for (int i = 0; i < MaxParams; i++) args_q[i] <= '0;
		end else if (cmd.clear) begin
			inter_q <= '0;
			argc_q <= '0;
			oscc_q <= '0;
			for (int i = 0; i < MaxParams; i++) args_q[i] <= '0;
		end else begin
			if (cmd.keep_int && inter_q == '0) inter_q <= c[6:0];
			if (cmd.osc_push) oscc_q <= oscc_q + 1'b1;
			if (cmd.take_param) begin
				if (c == 21'h3b) begin
					if (argc_q == '0) argc_q <= ArgCntW'(2);
					else if (argc_q < ArgCntW'(MaxParams)) argc_q <= argc_q + 1'b1;
				end else begin
					if (argc_q == '0) argc_q <= ArgCntW'(1);
					if (args_q[cur] < ValW'(9999))
						args_q[cur] <= ValW'(args_q[cur] * 10) + ValW'(c[3:0]);
				end
			end
		end
	end

	// OSC character store and its registered read port.
	always_ff @(posedge clk) begin
		if (cmd.osc_push) osc_mem[oscc_q[OscIdxW-1:0]] <= c[6:0];
		osc_rd_q <= osc_mem[idx_q[OscIdxW-1:0]];
	end

	// The output slot fills on a single event or a burst step and empties when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (cmd.load_ev || emit) begin
			oval_q <= 1'b1;
		end else if (out_ready) begin
			oval_q <= 1'b0;
		end
	end

	// Burst sequencer: pend_q spends one cycle letting the read register fill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q <= 1'b0;
			pend_q <= 1'b0;
			is_osc_q <= 1'b0;
			idx_q <= '0;
			tot_q <= '0;
			o_kind <= '0;
			o_code <= '0;
			o_inter <= '0;
			o_count <= '0;
			o_index <= '0;
			o_value <= '0;
			o_last <= 1'b0;
		end else begin
			if (cmd.load_ev) begin
				o_kind <= cmd.ev_kind;
				o_code <= cmd.ev_code;
				o_inter <= (cmd.ev_kind == EV_ESCAPE) ? inter_q : 7'd0;
				o_count <= (cmd.ev_kind == EV_ESCAPE && inter_q != '0) ? 7'd1 : 7'd0;
				o_index <= '0;
				o_value <= '0;
				o_last <= 1'b1;
			end else if (cmd.start_burst) begin
				burst_q <= 1'b1;
				pend_q <= 1'b1;
				is_osc_q <= (cmd.ev_kind == EV_OSC);
				o_kind <= cmd.ev_kind;
				o_code <= cmd.ev_code;
				o_inter <= inter_q;
				idx_q <= '0;
				tot_q <= (cmd.ev_kind == EV_OSC) ? 7'(oscc_q) : 7'(argc_q);
			end else if (pend_q) begin
				pend_q <= 1'b0;
			end else if (emit) begin
				o_count <= tot_q;
				o_index <= idx_q[5:0];
				o_value <= (tot_q == '0) ? '0 :
					(is_osc_q ? ValW'(osc_rd_q) : arg_rd);
				o_last <= (tot_q == '0) || (idx_q == tot_q - 1'b1);
				if ((tot_q == '0) || (idx_q == tot_q - 1'b1)) begin
					burst_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
					pend_q <= 1'b1;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> burst_q)
		else $error("read wait outside a burst");
	assert property (@(posedge clk) disable iff (!arst_n)
		burst_q && !pend_q |-> idx_q <= tot_q)
		else $error("burst index past count");
	assert property (@(posedge clk) disable iff (!arst_n)
		argc_q <= ArgCntW'(MaxParams))
		else $error("argument count overflow");
endmodule
`default_nettype wire
